[hw/rtl/lfsf_pkg.sv]
// ---------------------------------------------------------------------------
// Largest free square finder package
// Shared widths, map limits, line buffer port type and a three-way minimum.
// ---------------------------------------------------------------------------
package lfsf_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int SizeW     = 11;

   typedef struct packed {
      logic             en;
      logic [ColW-1:0]  addr;
      logic [SizeW-1:0] data;
   } lfsf_wr_type;

   function automatic logic [SizeW-1:0] min3(input logic [SizeW-1:0] a,
                                             input logic [SizeW-1:0] b,
                                             input logic [SizeW-1:0] c);
      logic [SizeW-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

endpackage

[hw/rtl/lfsf_line_buffer.sv]
// ---------------------------------------------------------------------------
// Line buffer
// One row of square sizes, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lfsf_line_buffer
   import lfsf_pkg::*;
(
   input  logic             clock,
   input  lfsf_wr_type      wr,
   input  logic             rd_en,
   input  logic [ColW-1:0]  rd_addr,
   output logic [SizeW-1:0] rd_data
);

   logic [SizeW-1:0] mem [MaxWidth];
   logic [SizeW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/largest_free_square_finder_unit.sv]
// ---------------------------------------------------------------------------
// Largest free square finder
// Finds the largest all-free square in a streamed grid map.
// ---------------------------------------------------------------------------
// Cells enter in row-major order at one per cycle unless the input stalls. A
// cell's line buffer read happens at the edge that accepts its request, and
// the three-way minimum and the best-square update load the result register
// as the cell leaves stage two, which raises the result request for a last
// cell. Line buffer entries not yet written since reset read as zero. The
// result request appears only for the cell marked last; the input stalls only
// while a finished result waits and another last cell is ready to replace it.
// Set the grid width only while the block is idle.
module largest_free_square_finder_unit
   import lfsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] cell_free, [7:1] zero
   input  logic        req_tlast,   // last_cell
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] size, [20:11] row, [30:21] col
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   logic [SizeW-1:0] grid_width_ff;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic             hfull_ff, hfull_in;
   logic [ColW:0]    fill_ff;

   logic             s1_valid_ff, s1_free_ff, s1_last_ff, s1_hfull_ff;
   logic             s1_eor_ff, s1_hit_ff;
   logic [ColW-1:0]  s1_col_ff;
   logic [RowW-1:0]  s1_row_ff;
   logic [SizeW-1:0] s1_fwd_ff;

   logic [SizeW-1:0] left_ff, diag_ff;
   logic [SizeW-1:0] best_size_ff, best_size_in;
   logic [RowW-1:0]  best_row_ff, best_row_in;
   logic [ColW-1:0]  best_col_ff, best_col_in;

   logic             rsp_valid_ff;
   logic [31:0]      rsp_data_ff;

   logic [SizeW-1:0] eff_width, col_next, up, size_cur, row_diff, col_diff;
   logic             eor, accept, s1_adv, s1_go, hit;
   logic [SizeW-1:0] rd_data;
   lfsf_wr_type      wr;

   assign csr_ready = 1'b1;

   always_comb begin
      if (grid_width_ff == '0) begin
         eff_width = SizeW'(1);
      end else if (grid_width_ff > SizeW'(MaxWidth)) begin
         eff_width = SizeW'(MaxWidth);
      end else begin
         eff_width = grid_width_ff;
      end
   end

   assign s1_adv     = !(s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready);
   assign s1_go      = s1_valid_ff && s1_adv;
   assign req_tready = s1_adv;
   assign accept     = req_tvalid && s1_adv;

   assign col_next = {1'b0, col_ff} + SizeW'(1);
   assign eor      = col_next >= eff_width;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      hfull_in = hfull_ff;
      if (req_tlast) begin
         col_in   = '0;
         row_in   = '0;
         hfull_in = 1'b0;
      end else if (!hfull_ff) begin
         if (eor) begin
            col_in = '0;
            if (row_ff == RowW'(MaxHeight - 1)) begin
               hfull_in = 1'b1;
            end else begin
               row_in = row_ff + RowW'(1);
            end
         end else begin
            col_in = col_next[ColW-1:0];
         end
      end
   end

   // Recurrence for the cell in the second stage.
   always_comb begin
      if (s1_row_ff == '0) begin
         up = '0;
      end else if (s1_hit_ff) begin
         up = s1_fwd_ff;
      end else if ({1'b0, s1_col_ff} < fill_ff) begin
         up = rd_data;
      end else begin
         up = '0;
      end
      size_cur = s1_free_ff ? (min3(up, left_ff, diag_ff) + SizeW'(1)) : '0;
      row_diff = {1'b0, s1_row_ff} + SizeW'(1) - size_cur;
      col_diff = {1'b0, s1_col_ff} + SizeW'(1) - size_cur;
   end

   always_comb begin
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (!s1_hfull_ff && (size_cur > best_size_ff)) begin
         best_size_in = size_cur;
         best_row_in  = row_diff[RowW-1:0];
         best_col_in  = col_diff[ColW-1:0];
      end
   end

   assign wr.en   = s1_go && !s1_hfull_ff;
   assign wr.addr = s1_col_ff;
   assign wr.data = size_cur;
   assign hit     = wr.en && (s1_col_ff == col_ff);

   lfsf_line_buffer u_line_buffer (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= SizeW'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         hfull_ff      <= 1'b0;
         fill_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         diag_ff       <= '0;
         best_size_ff  <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            grid_width_ff <= csr_data;
         end
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            hfull_ff <= hfull_in;
         end
         // Columns are always written in order from zero, so the written
         // entries form a prefix of the line buffer.
         if (wr.en && ({1'b0, wr.addr} == fill_ff)) begin
            fill_ff <= fill_ff + (ColW+1)'(1);
         end
         if (s1_adv) begin
            s1_valid_ff <= accept;
         end
         if (s1_go && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            if (s1_last_ff) begin
               left_ff      <= '0;
               diag_ff      <= '0;
               best_size_ff <= '0;
               best_row_ff  <= '0;
               best_col_ff  <= '0;
            end else begin
               best_size_ff <= best_size_in;
               best_row_ff  <= best_row_in;
               best_col_ff  <= best_col_in;
               if (!s1_hfull_ff) begin
                  if (s1_eor_ff) begin
                     left_ff <= '0;
                     diag_ff <= '0;
                  end else begin
                     left_ff <= size_cur;
                     diag_ff <= up;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_free_ff  <= req_tdata[0];
         s1_last_ff  <= req_tlast;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_hfull_ff <= hfull_ff;
         s1_eor_ff   <= eor;
         s1_hit_ff   <= hit;
         s1_fwd_ff   <= size_cur;
      end
      if (s1_go && s1_last_ff) begin
         rsp_data_ff <= {1'b0, best_col_in, best_row_in, best_size_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[verif/largest_free_square_finder_unit_test.sv]
// ---------------------------------------------------------------------------
// Largest free square finder unit test
// Streams grid maps cell by cell into the finder and checks each reported
// square against a cycle-free model of the maximal-square recurrence kept in
// this bench. Directed maps cover single cells, maps with no free cell, equal
// squares, width saturation and changes, the widest and tallest maps and a
// long output stall; random maps of mostly small widths follow, with random
// gaps on both streams.
// ---------------------------------------------------------------------------
module largest_free_square_finder_unit_test;
   import lfsf_pkg::*;

   typedef struct {
      logic [SizeW-1:0] size;
      logic [RowW-1:0]  row;
      logic [ColW-1:0]  col;
   } square_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [0] cell_free, [7:1] zero
   logic        req_tlast;   // last_cell
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [10:0] size, [20:11] row, [30:21] col
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_data;

   square_type expected_squares[$];
   int      error_count = 0;
   int      req_gap_max = 16;
   int      rsp_gap_max = 16;
   int      rsp_wait = 0;
   int      hold_off_cycles = 0;

   logic [SizeW-1:0] width_reg;
   logic [SizeW-1:0] row_above[MaxWidth];
   logic [SizeW-1:0] left_sz;
   logic [SizeW-1:0] diag_sz;
   logic [SizeW-1:0] best_sz;
   logic [RowW-1:0]  row_pos;
   logic [RowW-1:0]  best_row;
   logic [ColW-1:0]  col_pos;
   logic [ColW-1:0]  best_col;
   logic             rows_full;

   largest_free_square_finder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic clear_map_state();
      left_sz   = '0;
      diag_sz   = '0;
      row_pos   = '0;
      col_pos   = '0;
      best_sz   = '0;
      best_row  = '0;
      best_col  = '0;
      rows_full = 1'b0;
   endtask

   task automatic predict_cell(input logic free, input logic last);
      int               eff_w;
      logic [SizeW-1:0] up;
      logic [SizeW-1:0] s;
      square_type       sq;
      if (width_reg == '0) eff_w = 1;
      else if (int'(width_reg) > MaxWidth) eff_w = MaxWidth;
      else eff_w = int'(width_reg);
      if (!rows_full) begin
         up = (row_pos == '0) ? '0 : row_above[col_pos];
         s = up;
         if (left_sz < s) s = left_sz;
         if (diag_sz < s) s = diag_sz;
         s = free ? s + 1'b1 : '0;
         row_above[col_pos] = s;
         diag_sz = up;
         left_sz = s;
         if (s > best_sz) begin
            best_sz  = s;
            best_row = RowW'(int'(row_pos) + 1 - int'(s));
            best_col = ColW'(int'(col_pos) + 1 - int'(s));
         end
         if (int'(col_pos) + 1 >= eff_w) begin
            col_pos = '0;
            left_sz = '0;
            diag_sz = '0;
            if (int'(row_pos) + 1 >= MaxHeight) rows_full = 1'b1;
            else row_pos = row_pos + 1'b1;
         end else begin
            col_pos = col_pos + 1'b1;
         end
      end
      if (last) begin
         sq.size = best_sz;
         sq.row  = best_row;
         sq.col  = best_col;
         expected_squares.push_back(sq);
         clear_map_state();
      end
   endtask

   // Drives one cell request and returns at the edge that accepts it.
   task automatic send_cell(input logic free, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, free};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_cell(free, last);
   endtask

   task automatic send_grid(input string cells, input bit end_map = 1'b1);
      for (int i = 0; i < cells.len(); i++)
         send_cell(cells[i] == "1", end_map && i == cells.len() - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_squares.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_width(input logic [10:0] value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      width_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_single_cells();
      send_grid("0");
      send_grid("1");
      send_grid("011");
      send_grid("11");
   endtask

   task automatic test_no_free_cells();
      write_width(11'd3);
      send_grid("000000");
   endtask

   task automatic test_equal_squares();
      write_width(11'd5);
      send_grid("1101111011");
      write_width(11'd4);
      send_grid("0111011101111111");
      // The row above is ignored on the first row even though it holds a three.
      send_grid("11111111");
   endtask

   task automatic test_zero_width();
      write_width(11'd0);
      send_grid("1111");
   endtask

   task automatic test_width_change_in_map();
      write_width(11'd4);
      send_grid("111111", 1'b0);
      write_width(11'd2);
      send_grid("1", 1'b0);
      send_grid("1111");
      write_width(11'd2);
      send_grid("111", 1'b0);
      write_width(11'd6);
      send_grid("11111111111");
   endtask

   task automatic test_widest_map();
      req_gap_max = 2;
      rsp_gap_max = 2;
      write_width(11'd2047);
      for (int i = 0; i < MaxWidth; i++) send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b1);
      req_gap_max = 16;
      rsp_gap_max = 16;
   endtask

   task automatic test_tallest_map();
      req_gap_max = 2;
      write_width(11'd1);
      for (int i = 0; i < MaxHeight - 1; i++) send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0);
      send_grid("1111");
      req_gap_max = 16;
   endtask

   task automatic test_output_stall();
      write_width(11'd2);
      req_gap_max = 0;
      hold_off_cycles = 200;
      for (int i = 0; i < 24; i++) begin
         case (i % 4)
            0: send_grid("11");
            1: send_grid("01");
            2: send_grid("10");
            default: send_grid("00");
         endcase
      end
      req_gap_max = 16;
   endtask

   task automatic test_random_maps();
      int          cells_sent;
      int          maps_done;
      int          eff_w;
      int          n_cells;
      int          density;
      int          switch_at;
      logic [10:0] w;
      cells_sent = 0;
      maps_done  = 0;
      while (cells_sent < 200 || maps_done < 12) begin
         case ($urandom_range(0, 19))
            0: w = 11'($urandom_range(0, 2047));
            1, 2, 3: w = 11'($urandom_range(9, 64));
            default: w = 11'($urandom_range(1, 8));
         endcase
         if (maps_done == 0 || $urandom_range(0, 2) == 0) write_width(w);
         if (width_reg == '0) eff_w = 1;
         else if (int'(width_reg) > MaxWidth) eff_w = MaxWidth;
         else eff_w = int'(width_reg);
         if (eff_w > 64) n_cells = $urandom_range(1, 64);
         else if (eff_w > 8) n_cells = eff_w * $urandom_range(1, 3) + $urandom_range(0, eff_w - 1);
         else n_cells = eff_w * $urandom_range(1, 8) + $urandom_range(0, eff_w - 1);
         case ($urandom_range(0, 3))
            0: density = 50;
            1: density = 75;
            2: density = 90;
            default: density = 100;
         endcase
         switch_at = -1;
         if (n_cells > 1 && $urandom_range(0, 7) == 0) switch_at = $urandom_range(1, n_cells - 1);
         if ($urandom_range(0, 3) == 0) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = 16;
            rsp_gap_max = 16;
         end
         for (int i = 0; i < n_cells; i++) begin
            if (i == switch_at) write_width(11'($urandom_range(1, 8)));
            send_cell($urandom_range(0, 99) < density, i == n_cells - 1);
         end
         cells_sent += n_cells;
         maps_done++;
      end
   endtask

   always @(posedge clock) begin : check_squares
      square_type sq;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_wait = $urandom_range(0, rsp_gap_max);
         if (expected_squares.size() == 0) begin
            report_mismatch("unexpected square size", rsp_tdata[10:0], 0);
         end else begin
            sq = expected_squares.pop_front();
            if (rsp_tdata[10:0] !== sq.size)
               report_mismatch("square_size", rsp_tdata[10:0], sq.size);
            if (rsp_tdata[20:11] !== sq.row)
               report_mismatch("square_row", rsp_tdata[20:11], sq.row);
            if (rsp_tdata[30:21] !== sq.col)
               report_mismatch("square_col", rsp_tdata[30:21], sq.col);
         end
      end
   end

   initial begin : drain_squares
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL largest_free_square_finder_unit");
      $finish;
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      foreach (row_above[i]) row_above[i] = '0;
      width_reg = 11'd1;
      clear_map_state();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_single_cells();
      test_no_free_cells();
      test_equal_squares();
      test_zero_width();
      test_width_change_in_map();
      test_widest_map();
      test_tallest_map();
      test_output_stall();
      test_random_maps();

      @(negedge clock);
      req_tvalid <= 1'b0;
      for (int i = 0; i < 5000 && expected_squares.size() > 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_squares.size() > 0)
         report_mismatch("squares never delivered", 0, expected_squares.size());
      if (error_count == 0) begin
         $display("PASS largest_free_square_finder_unit");
      end else begin
         $display("FAIL largest_free_square_finder_unit");
      end
      $finish;
   end

endmodule
